// ===== rtl/mlenc_pkg.sv =====
package mlenc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MAG_W    = 14;
   localparam int CODE_W   = 7;
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 2 * BYTE_W;

   localparam int SEG_COUNT = 8;

   // Upper end of each segment, in shifted magnitude
   localparam logic [MAG_W-1:0] SEG_BOUND [SEG_COUNT] = '{
      14'd31, 14'd95, 14'd223, 14'd479, 14'd991, 14'd2015, 14'd4063, 14'd7903
   };

   // Magnitude that a segment's steps count from
   localparam logic [MAG_W-1:0] SEG_BASE [SEG_COUNT] = '{
      14'd1, 14'd31, 14'd95, 14'd223, 14'd479, 14'd991, 14'd2015, 14'd4063
   };

   // Code at the start of each segment
   localparam logic [CODE_W-1:0] SEG_OFFSET [SEG_COUNT] = '{
      7'd1, 7'd16, 7'd32, 7'd48, 7'd64, 7'd80, 7'd96, 7'd112
   };

   localparam logic [MAG_W-1:0]  MAG_LINEAR_MAX = 14'd1;
   localparam logic [CODE_W-1:0] CODE_MAX       = 7'd127;
   localparam logic [BYTE_W-1:0] NEG_BIAS       = 8'd127;
   localparam logic [BYTE_W-1:0] POS_BIAS       = 8'd255;

   // What the packer offers for the item at its input
   typedef struct packed {
      logic              produce;
      logic [WORD_W-1:0] word;
      logic              last_word;
      logic              high_byte_next;
   } pack_result_type;

endpackage

// ===== rtl/mlenc_segment_encoder.sv =====
module mlenc_segment_encoder
   import mlenc_pkg::*;
(
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic        [BYTE_W-1:0]   code_byte
);

   logic              neg;
   logic [MAG_W-1:0]  shr;
   logic [MAG_W-1:0]  mag;
   logic [CODE_W-1:0] code;

   // Floor-divide by four, then take the magnitude
   assign neg = sample[SAMPLE_W-1];
   assign shr = sample[SAMPLE_W-1:2];
   assign mag = neg ? (~shr + MAG_W'(1)) : shr;

   // Pick the lowest segment that holds the magnitude, saturate above the last
   always_comb begin
      code = CODE_MAX;
      for (int i = SEG_COUNT - 1; i >= 0; i--) begin
         if (mag <= SEG_BOUND[i]) begin
            code = CODE_W'(MAG_W'(mag - SEG_BASE[i]) >> (i + 1)) + SEG_OFFSET[i];
         end
      end
      if (mag <= MAG_LINEAR_MAX) begin
         code = CODE_W'(mag);
      end
   end

   // Fold the sign into the byte
   assign code_byte = neg ? (NEG_BIAS - {1'b0, code}) : (POS_BIAS - {1'b0, code});

endmodule

// ===== rtl/mlenc_packer.sv =====
module mlenc_packer
   import mlenc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [BYTE_W-1:0]  code_byte,
   input  logic               last,
   output pack_result_type    result
);

   logic [BYTE_W-1:0] held_low_byte_ff;
   logic [BYTE_W-1:0] held_low_byte_in;
   logic              high_byte_next_ff;
   logic              high_byte_next_in;

   // Form the word on offer: full pair, or half word flushed at buffer end
   always_comb begin
      result.produce        = high_byte_next_ff || last;
      result.last_word      = last;
      result.high_byte_next = high_byte_next_ff;
      if (high_byte_next_ff) begin
         result.word = {code_byte, held_low_byte_ff};
      end else begin
         result.word = {{BYTE_W{1'b0}}, code_byte};
      end
   end

   // Hold the first byte of a pair, drop it once the word leaves
   always_comb begin
      held_low_byte_in  = held_low_byte_ff;
      high_byte_next_in = high_byte_next_ff;
      if (advance) begin
         if (result.produce) begin
            held_low_byte_in  = '0;
            high_byte_next_in = 1'b0;
         end else begin
            held_low_byte_in  = code_byte;
            high_byte_next_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_low_byte_ff  <= '0;
         high_byte_next_ff <= 1'b0;
      end else begin
         held_low_byte_ff  <= held_low_byte_in;
         high_byte_next_ff <= high_byte_next_in;
      end
   end

endmodule

// ===== rtl/mu_law_sample_encoder_packer.sv =====
// Mu-law style sample encoder and packer. Each signed 16-bit sample on the req
// channel is encoded to one byte, and bytes are packed two to a 16-bit word on
// the rsp channel, earlier byte in bits 7:0. A sample marked end_of_buffer
// closes the word at once: a half word goes out with bits 15:8 zero, and
// rsp_last_word is set on that word. One sample is taken every clock cycle
// while the input does not stall; a sample passes an input register, the
// segment encoder and the packer, and a word that it completes is loaded
// into the output register, which drives rsp. Input stalls only while a
// finished word in the output register is not taken and the sample waiting
// behind it would produce another.
module mu_law_sample_encoder_packer
   import mlenc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_end_of_buffer,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic        [WORD_W-1:0]   rsp_packed_word,
   output logic                       rsp_last_word
);

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       s1_last_ff;
   logic                       s1_advance;

   logic [BYTE_W-1:0]          code_byte;
   pack_result_type            pack;

   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [WORD_W-1:0]          out_word_ff;
   logic                       out_last_ff;
   logic                       out_load;

   // Advance the registered item when its word, if any, has room
   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready || !pack.produce);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign out_load   = s1_advance && pack.produce;

   // Input register
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_sample_ff <= req_sample;
         s1_last_ff   <= req_end_of_buffer;
      end
   end

   mlenc_segment_encoder u_encoder (
      .sample    (s1_sample_ff),
      .code_byte (code_byte)
   );

   mlenc_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_advance),
      .code_byte (code_byte),
      .last      (s1_last_ff),
      .result    (pack)
   );

   // Output register: load a finished word, clear once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_word_ff <= pack.word;
         out_last_ff <= pack.last_word;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_packed_word = out_word_ff;
   assign rsp_last_word   = out_last_ff;

   // A first byte without buffer end waits for its partner
   a_pair_pending: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !pack.produce |=> pack.high_byte_next)
      else $error("first byte not held for pairing");

   // Every word sent leaves the packer at the low byte position
   a_word_resets_pos: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff && !pack.high_byte_next)
      else $error("byte position not reset after word");

   // A flushed half word carries a zero high byte and the end mark
   a_half_flush: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !pack.high_byte_next && s1_last_ff
      |=> rsp_valid && rsp_last_word && rsp_packed_word[WORD_W-1:BYTE_W] == '0)
      else $error("half word flush malformed");

   // A stalled word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !out_load)
      else $error("pending word overwritten");

endmodule
